// ===== hw/rtl/pds_pkg.sv =====
// ----------------------------------------------------------------------------
// pds_pkg
// Shared constants and types for the packet deframer with additive checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

	localparam int MAX_PAYLOAD = 16;
	localparam int STORE_DEPTH = 16;
	localparam int STORE_LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int TDATA_W     = 32;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] LIMIT_BYTE = 8'(STORE_LIMIT);

	typedef enum logic [1:0] {
		ST_PAYLOAD  = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_CSUM_ERR = 2'd2,
		ST_OVERSIZE = 2'd3
	} status_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic     valid;
		status_t  status;
		logic [7:0] command;
		logic [7:0] length;
	} job_t;

endpackage

// ===== hw/rtl/pds_ram.sv =====
// ----------------------------------------------------------------------------
// pds_ram
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/pds_framer.sv =====
// ----------------------------------------------------------------------------
// pds_framer
// Sync hunt, header capture, payload store writes and checksum verification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	input  logic [7:0]       rx_byte,
	output pds_pkg::ram_wr_t wr,
	output pds_pkg::job_t    job
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_CMD  = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_CKH  = 3'd4,
		PH_CKL  = 3'd5
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  command_q;
	logic [7:0]  length_q;
	logic [7:0]  count_q;
	logic [15:0] sum_q;
	logic [7:0]  ckh_q;
	logic [7:0]  count_nxt;
	logic        sum_ok;

	assign count_nxt = count_q + 8'd1;
	assign sum_ok    = (sum_q == {ckh_q, rx_byte});

	always_comb begin
		wr.en   = byte_valid && (phase_q == PH_DATA) && (count_q < pds_pkg::LIMIT_BYTE);
		wr.addr = count_q[pds_pkg::IDX_W-1:0];
		wr.data = rx_byte;
	end

	always_comb begin
		job.valid   = byte_valid && (phase_q == PH_CKL);
		job.command = command_q;
		job.length  = length_q;
		priority if (length_q > pds_pkg::LIMIT_BYTE) begin
			job.status = pds_pkg::ST_OVERSIZE;
		end else if (!sum_ok) begin
			job.status = pds_pkg::ST_CSUM_ERR;
		end else if (length_q == 8'd0) begin
			job.status = pds_pkg::ST_EMPTY;
		end else begin
			job.status = pds_pkg::ST_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			command_q <= '0;
			length_q  <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			ckh_q     <= '0;
		end else if (byte_valid) begin
			unique case (phase_q)
				PH_CMD: begin
					command_q <= rx_byte;
					sum_q     <= sum_q + 16'(rx_byte);
					phase_q   <= PH_LEN;
				end
				PH_LEN: begin
					length_q <= rx_byte;
					count_q  <= '0;
					sum_q    <= sum_q + 16'(rx_byte);
					phase_q  <= (rx_byte == 8'd0) ? PH_CKH : PH_DATA;
				end
				PH_DATA: begin
					sum_q   <= sum_q + 16'(rx_byte);
					count_q <= count_nxt;
					if (count_nxt >= length_q) begin
						phase_q <= PH_CKH;
					end
				end
				PH_CKH: begin
					ckh_q   <= rx_byte;
					phase_q <= PH_CKL;
				end
				PH_CKL: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					if (rx_byte == pds_pkg::SYNC_BYTE) begin
						sum_q   <= 16'(pds_pkg::SYNC_BYTE);
						phase_q <= PH_CMD;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/pds_replay.sv =====
// ----------------------------------------------------------------------------
// pds_replay
// Packet result sequencer: reads the payload store and drives the result
// stream through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_replay (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pds_pkg::job_t               job,
	input  logic [7:0]                  rd_data,
	output logic                        rd_en,
	output logic [pds_pkg::IDX_W-1:0]   rd_addr,
	output logic                        busy,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pds_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);

	typedef enum logic [1:0] {
		R_IDLE = 2'd0,
		R_LOAD = 2'd1,
		R_SEND = 2'd2
	} rstate_t;

	rstate_t                   state_q;
	logic [pds_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                cmd_q;
	logic [7:0]                len_q;
	logic                      last_q;
	logic [pds_pkg::IDX_W-1:0] idx_nxt;
	logic                      is_last;
	logic                      send_done;

	assign idx_nxt   = idx_q + pds_pkg::IDX_W'(1);
	assign is_last   = ((8'(idx_q) + 8'd1) == len_q);
	assign send_done = (state_q == R_SEND) && m_tready;
	assign busy      = (state_q != R_IDLE);
	assign m_tvalid  = (state_q == R_SEND);
	assign m_tlast   = last_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_nxt;
		if (state_q == R_IDLE) begin
			rd_en   = job.valid && (job.status == pds_pkg::ST_PAYLOAD);
			rd_addr = '0;
		end else if (send_done && !last_q) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			idx_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			last_q  <= 1'b0;
			m_tdata <= '0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					idx_q <= '0;
					cmd_q <= job.command;
					len_q <= job.length;
					if (job.valid) begin
						if (job.status == pds_pkg::ST_PAYLOAD) begin
							state_q <= R_LOAD;
						end else begin
							m_tdata <= {2'b00, 8'd0, 4'd0, job.length, job.command,
								job.status};
							last_q  <= 1'b1;
							state_q <= R_SEND;
						end
					end
				end
				R_LOAD: begin
					m_tdata <= {2'b00, rd_data, idx_q, len_q, cmd_q, pds_pkg::ST_PAYLOAD};
					last_q  <= is_last;
					state_q <= R_SEND;
				end
				R_SEND: begin
					if (m_tready) begin
						if (last_q) begin
							state_q <= R_IDLE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= R_LOAD;
						end
					end
				end
				default: begin
					state_q <= R_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/packet_deframer_sum_check_top.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_sum_check_top
// Sync-byte/length deframer with 16-bit additive checksum check.
//
// Input stream (s_*): one received link byte per transfer. Bytes are dropped
// until the 0xFF sync byte, then command, length, payload and two checksum
// bytes (high first) are taken. Bytes are accepted while s_tready is high;
// payload bytes are written to a 16-entry synchronous RAM.
// Output stream (m_*): on the low checksum byte a good packet replays its
// payload, one transfer per byte with tlast on the final one; an empty,
// corrupt or oversize packet gives one status transfer with tlast.
// A status result is registered and valid in the cycle after the closing
// byte; a payload result passes R_LOAD, then R_SEND. Each payload byte is
// read from the RAM in R_LOAD, then held in R_SEND until it is taken.
// s_tready is low while results of a finished packet are pending; a stall on
// m_tready holds the current result and keeps the input side closed.
// Reset clears the framing state and the result sequencer; the payload RAM
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_deframer_sum_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [1:0] status, [9:2] command, [17:10] payload_length,
	                              // [21:18] byte_index, [29:22] payload_byte, [31:30] zero
	output logic        m_tlast   // last
);

	pds_pkg::ram_wr_t          wr;
	pds_pkg::job_t             job;
	logic                      busy;
	logic                      rd_en;
	logic [pds_pkg::IDX_W-1:0] rd_addr;
	logic [7:0]                rd_data;

	assign s_tready = !busy;

	pds_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid && s_tready),
		.rx_byte    (s_tdata),
		.wr         (wr),
		.job        (job)
	);

	pds_ram #(
		.DEPTH (pds_pkg::STORE_DEPTH),
		.WIDTH (8)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pds_replay u_replay (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.rd_data  (rd_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
